@@ rtl/core/dcrc_pkg.sv @@
// shared types and constants for the drive can reply classifier
// no dependencies; used by dcrc_decode and drive_can_reply_classifier
package dcrc_pkg;

    localparam int unsigned POS_W   = 40;
    localparam int unsigned SCALE_W = 32;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned FAULT_W = 5;
    localparam int unsigned NUM_FAULTS = 23;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd386546747;

    // reply kinds
    localparam logic [KIND_W-1:0] KIND_ENCODER     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BUF_FULL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BUF_EMPTY   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BUF_OTHER   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MOVE_ENDED  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TARGET      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CONTROL     = 3'd6;
    localparam logic [KIND_W-1:0] KIND_EMERGENCY   = 3'd7;

    localparam logic [FAULT_W-1:0] FAULT_NONE    = 5'd0;
    localparam logic [FAULT_W-1:0] FAULT_UNKNOWN = 5'd24;

    // frame byte values
    localparam logic [7:0] B_OBJ_POS_LO  = 8'h64;
    localparam logic [7:0] B_OBJ_HI      = 8'h60;
    localparam logic [7:0] B_OBJ_TGT_LO  = 8'h41;
    localparam logic [7:0] B_CTRL_LO     = 8'h01;
    localparam logic [7:0] B_CTRL_HI     = 8'hFF;
    localparam logic [7:0] B_BUF_SUB     = 8'h01;
    localparam logic [7:0] B_BUF_FULL    = 8'h20;
    localparam logic [7:0] B_BUF_EMPTY   = 8'h00;
    localparam logic [7:0] B_BUF_OTHER   = 8'h08;
    localparam logic [7:0] B_END_LO      = 8'h37;
    localparam logic [7:0] B_END_HI      = 8'h96;

    // emergency code pairs {byte1, byte0}, fault code is position plus one
    localparam logic [15:0] FAULT_PAIRS [NUM_FAULTS] = '{
        16'h0000, 16'h1000, 16'h2310, 16'h2340, 16'h3210, 16'h3220, 16'h4280,
        16'h4310, 16'h5441, 16'h5442, 16'h5443, 16'h6100, 16'h7500, 16'h8110,
        16'h8130, 16'h8331, 16'h8580, 16'h8611, 16'h9000, 16'hFF02, 16'hFF03,
        16'hFF04, 16'hFF05
    };

    // per-word state update controls from the decoder
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FAULT_W-1:0] fault;
        logic               pos_load;
        logic               full_set;
        logic               full_clr;
        logic               done_set;
        logic               target_load;
        logic               target_val;
    } t_class;

    function automatic logic [FAULT_W-1:0] fault_code(input logic [15:0] key);
        logic [FAULT_W-1:0] code;
        code = FAULT_UNKNOWN;
        for (int i = 0; i < NUM_FAULTS; i++) begin
            if (FAULT_PAIRS[i] == key) begin
                code = FAULT_W'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

@@ rtl/core/drive_can_reply_classifier.sv @@
// top level of the drive can reply classifier: input register, decoder, result register
// depends on dcrc_pkg and dcrc_decode
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  in       | i_in_valid, o_in_ready, i_byte0..i_byte7 | frame in
//  out      | o_out_valid, i_out_ready, o_kind ..      | reply out
//  cfg      | i_cfg_valid, o_cfg_ready, i_position_scale | scale write
//
// a word passes the input register, then the result register; while results are taken,
// one word per cycle sustained, since decode and the 32x33 multiply finish in one pass.
// synchronous active-low reset clears both valid stages, the kept position and flags,
// and loads the default scale. a stalled result holds the pipe: the input register
// still takes a word while it is empty or its word moves to the result stage.
module drive_can_reply_classifier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_byte0,
    input  logic [7:0]                         i_byte1,
    input  logic [7:0]                         i_byte2,
    input  logic [7:0]                         i_byte3,
    input  logic [7:0]                         i_byte4,
    input  logic [7:0]                         i_byte5,
    input  logic [7:0]                         i_byte6,
    input  logic [7:0]                         i_byte7,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [dcrc_pkg::KIND_W-1:0]        o_kind,
    output logic [dcrc_pkg::FAULT_W-1:0]       o_fault,
    output logic signed [dcrc_pkg::POS_W-1:0]  o_position,
    output logic                               o_target_reached,
    output logic                               o_movement_done,
    output logic                               o_buffer_full,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dcrc_pkg::SCALE_W-1:0]       i_position_scale
);

    logic                              r_in_valid;
    logic [7:0]                        r_b0, r_b1, r_b2, r_b3, r_b4, r_b5, r_b6, r_b7;
    logic                              r_out_valid;
    logic [dcrc_pkg::KIND_W-1:0]       r_kind;
    logic [dcrc_pkg::FAULT_W-1:0]      r_fault;
    logic [dcrc_pkg::POS_W-1:0]        r_position;
    logic                              r_target;
    logic                              r_done;
    logic                              r_full;
    logic [dcrc_pkg::SCALE_W-1:0]      r_scale;
    logic                              advance;
    logic                              in_take;
    dcrc_pkg::t_class                  cls;
    logic [dcrc_pkg::POS_W-1:0]        dec_position;

    // result stage frees up when empty or being taken
    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign in_take     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    dcrc_decode u_decode (
        .i_b0       (r_b0),
        .i_b1       (r_b1),
        .i_b2       (r_b2),
        .i_b3       (r_b3),
        .i_b4       (r_b4),
        .i_b5       (r_b5),
        .i_b6       (r_b6),
        .i_b7       (r_b7),
        .i_scale    (r_scale),
        .o_class    (cls),
        .o_position (dec_position)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= dcrc_pkg::SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_position_scale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_b0 <= i_byte0;
            r_b1 <= i_byte1;
            r_b2 <= i_byte2;
            r_b3 <= i_byte3;
            r_b4 <= i_byte4;
            r_b5 <= i_byte5;
            r_b6 <= i_byte6;
            r_b7 <= i_byte7;
        end
    end

    // kept state changes only when a result loads, so it doubles as the result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_position  <= '0;
            r_target    <= 1'b0;
            r_done      <= 1'b0;
            r_full      <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                if (cls.pos_load) begin
                    r_position <= dec_position;
                end
                if (cls.target_load) begin
                    r_target <= cls.target_val;
                end
                if (cls.done_set) begin
                    r_done <= 1'b1;
                end
                if (cls.full_set) begin
                    r_full <= 1'b1;
                end else if (cls.full_clr) begin
                    r_full <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_kind  <= cls.kind;
            r_fault <= cls.fault;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_fault          = r_fault;
    assign o_position       = r_position;
    assign o_target_reached = r_target;
    assign o_movement_done  = r_done;
    assign o_buffer_full    = r_full;

endmodule

@@ rtl/core/dcrc_decode.sv @@
// frame decoder: classifies one registered word and scales the encoder count
// depends on dcrc_pkg
module dcrc_decode (
    input  logic [7:0]                     i_b0,
    input  logic [7:0]                     i_b1,
    input  logic [7:0]                     i_b2,
    input  logic [7:0]                     i_b3,
    input  logic [7:0]                     i_b4,
    input  logic [7:0]                     i_b5,
    input  logic [7:0]                     i_b6,
    input  logic [7:0]                     i_b7,
    input  logic [dcrc_pkg::SCALE_W-1:0]   i_scale,
    output dcrc_pkg::t_class               o_class,
    output logic [dcrc_pkg::POS_W-1:0]     o_position
);

    logic signed [31:0] count;
    logic signed [32:0] scale_s;
    logic signed [64:0] product;
    logic               is_enc;
    logic               is_ctrl;
    logic               is_buf;
    logic               is_end;
    logic               is_tgt;

    // signed count times unsigned scale, floor shift by 24
    assign count      = {i_b7, i_b6, i_b5, i_b4};
    assign scale_s    = {1'b0, i_scale};
    assign product    = count * scale_s;
    assign o_position = product[63:24];

    assign is_enc  = (i_b1 == dcrc_pkg::B_OBJ_POS_LO) && (i_b2 == dcrc_pkg::B_OBJ_HI);
    assign is_ctrl = (i_b0 == dcrc_pkg::B_CTRL_LO) && (i_b1 == dcrc_pkg::B_CTRL_HI);
    assign is_buf  = is_ctrl && (i_b2 == dcrc_pkg::B_BUF_SUB);
    assign is_end  = (i_b0 == dcrc_pkg::B_END_LO) && (i_b1 == dcrc_pkg::B_END_HI);
    assign is_tgt  = (i_b1 == dcrc_pkg::B_OBJ_TGT_LO) && (i_b2 == dcrc_pkg::B_OBJ_HI);

    always_comb begin
        o_class            = '0;
        o_class.fault      = dcrc_pkg::FAULT_NONE;
        o_class.target_val = i_b5[2];
        if (is_enc) begin
            o_class.kind     = dcrc_pkg::KIND_ENCODER;
            o_class.pos_load = 1'b1;
        end else if (is_buf && i_b4 == dcrc_pkg::B_BUF_FULL) begin
            o_class.kind     = dcrc_pkg::KIND_BUF_FULL;
            o_class.full_set = 1'b1;
        end else if (is_buf && i_b4 == dcrc_pkg::B_BUF_EMPTY) begin
            o_class.kind     = dcrc_pkg::KIND_BUF_EMPTY;
            o_class.full_clr = 1'b1;
        end else if (is_buf && i_b3 == dcrc_pkg::B_BUF_OTHER) begin
            o_class.kind     = dcrc_pkg::KIND_BUF_OTHER;
        end else if (is_end) begin
            o_class.kind     = dcrc_pkg::KIND_MOVE_ENDED;
            o_class.done_set = 1'b1;
        end else if (is_tgt) begin
            o_class.kind        = dcrc_pkg::KIND_TARGET;
            o_class.target_load = 1'b1;
        end else if (is_ctrl) begin
            o_class.kind     = dcrc_pkg::KIND_CONTROL;
        end else begin
            o_class.kind     = dcrc_pkg::KIND_EMERGENCY;
            o_class.fault    = dcrc_pkg::fault_code({i_b1, i_b0});
        end
    end

endmodule

@@ verif/drive_can_reply_classifier_test.sv @@
// testbench for drive_can_reply_classifier: directed and random can frames,
// scale register writes between phases, replies checked against a built-in predictor
// depends on dcrc_pkg and drive_can_reply_classifier
`timescale 1ns / 100ps

module drive_can_reply_classifier_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_WORDS   = 250;

    // byte i of a frame is frame[i]
    typedef logic [7:0][7:0] t_frame;

    typedef enum logic [1:0] {CMD_FRAME, CMD_SCALE, CMD_DRAIN} t_cmd_op;

    typedef struct packed {
        t_cmd_op                       op;
        t_frame                        frame;
        logic [dcrc_pkg::SCALE_W-1:0]  scale;
    } t_command;

    typedef struct packed {
        logic [dcrc_pkg::KIND_W-1:0]        kind;
        logic [dcrc_pkg::FAULT_W-1:0]       fault;
        logic signed [dcrc_pkg::POS_W-1:0]  position;
        logic                               target;
        logic                               done;
        logic                               full;
    } t_reply;

    typedef enum int {
        SHAPE_ENCODER, SHAPE_BUF_FULL, SHAPE_BUF_EMPTY, SHAPE_BUF_OTHER,
        SHAPE_ENDED, SHAPE_TARGET, SHAPE_CONTROL, SHAPE_FAULT, SHAPE_NOISE
    } t_shape;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_ready;
    logic [7:0]                          i_byte0 = '0;
    logic [7:0]                          i_byte1 = '0;
    logic [7:0]                          i_byte2 = '0;
    logic [7:0]                          i_byte3 = '0;
    logic [7:0]                          i_byte4 = '0;
    logic [7:0]                          i_byte5 = '0;
    logic [7:0]                          i_byte6 = '0;
    logic [7:0]                          i_byte7 = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic [dcrc_pkg::KIND_W-1:0]         o_kind;
    logic [dcrc_pkg::FAULT_W-1:0]        o_fault;
    logic signed [dcrc_pkg::POS_W-1:0]   o_position;
    logic                                o_target_reached;
    logic                                o_movement_done;
    logic                                o_buffer_full;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [dcrc_pkg::SCALE_W-1:0]        i_position_scale = '0;

    // predictor state
    logic [dcrc_pkg::SCALE_W-1:0]        scale_now = dcrc_pkg::SCALE_RESET;
    logic signed [dcrc_pkg::POS_W-1:0]   pos_now = '0;
    logic                                target_now = 1'b0;
    logic                                done_now = 1'b0;
    logic                                full_now = 1'b0;

    t_command pending_words[$];
    t_reply   replies_due[$];

    int mismatch_count = 0;
    int reply_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int settle_left = SETTLE_CYCLES;
    int stall_mode = 0;
    int mode_left = 0;
    int pattern_step = 0;

    drive_can_reply_classifier u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_byte0          (i_byte0),
        .i_byte1          (i_byte1),
        .i_byte2          (i_byte2),
        .i_byte3          (i_byte3),
        .i_byte4          (i_byte4),
        .i_byte5          (i_byte5),
        .i_byte6          (i_byte6),
        .i_byte7          (i_byte7),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_fault          (o_fault),
        .o_position       (o_position),
        .o_target_reached (o_target_reached),
        .o_movement_done  (o_movement_done),
        .o_buffer_full    (o_buffer_full),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_position_scale (i_position_scale)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // classify one frame, update the kept position and flags, return the reply
    function automatic t_reply classify_frame(input t_frame f);
        t_reply              r;
        logic signed [31:0]  count;
        logic signed [64:0]  product;
        logic [15:0]         pair;
        logic                is_ctrl;
        logic                is_buf;
        r.fault = dcrc_pkg::FAULT_NONE;
        is_ctrl = (f[0] == dcrc_pkg::B_CTRL_LO) && (f[1] == dcrc_pkg::B_CTRL_HI);
        is_buf = is_ctrl && (f[2] == dcrc_pkg::B_BUF_SUB);
        if (f[1] == dcrc_pkg::B_OBJ_POS_LO && f[2] == dcrc_pkg::B_OBJ_HI) begin
            count = {f[7], f[6], f[5], f[4]};
            product = count * $signed({1'b0, scale_now});
            // floor of product / 2^24, exact value fits 40 bits
            pos_now = product[63:24];
            r.kind = dcrc_pkg::KIND_ENCODER;
        end else if (is_buf && f[4] == dcrc_pkg::B_BUF_FULL) begin
            full_now = 1'b1;
            r.kind = dcrc_pkg::KIND_BUF_FULL;
        end else if (is_buf && f[4] == dcrc_pkg::B_BUF_EMPTY) begin
            full_now = 1'b0;
            r.kind = dcrc_pkg::KIND_BUF_EMPTY;
        end else if (is_buf && f[3] == dcrc_pkg::B_BUF_OTHER) begin
            r.kind = dcrc_pkg::KIND_BUF_OTHER;
        end else if (f[0] == dcrc_pkg::B_END_LO && f[1] == dcrc_pkg::B_END_HI) begin
            done_now = 1'b1;
            r.kind = dcrc_pkg::KIND_MOVE_ENDED;
        end else if (f[1] == dcrc_pkg::B_OBJ_TGT_LO && f[2] == dcrc_pkg::B_OBJ_HI) begin
            target_now = f[5][2];
            r.kind = dcrc_pkg::KIND_TARGET;
        end else if (is_ctrl) begin
            r.kind = dcrc_pkg::KIND_CONTROL;
        end else begin
            r.kind = dcrc_pkg::KIND_EMERGENCY;
            r.fault = dcrc_pkg::FAULT_UNKNOWN;
            pair = {f[1], f[0]};
            for (int i = dcrc_pkg::NUM_FAULTS - 1; i >= 0; i--) begin
                if (dcrc_pkg::FAULT_PAIRS[i] == pair) begin
                    r.fault = dcrc_pkg::FAULT_W'(i + 1);
                end
            end
        end
        r.position = pos_now;
        r.target = target_now;
        r.done = done_now;
        r.full = full_now;
        return r;
    endfunction

    function automatic t_frame make_frame(input t_shape shape);
        t_frame       f;
        logic [31:0]  cnt;
        f = {$urandom, $urandom};
        case (shape)
            SHAPE_ENCODER: begin
                f[1] = dcrc_pkg::B_OBJ_POS_LO;
                f[2] = dcrc_pkg::B_OBJ_HI;
                case ($urandom_range(0, 7))
                    0: cnt = 32'h0000_0000;
                    1: cnt = 32'h7FFF_FFFF;
                    2: cnt = 32'h8000_0000;
                    3: cnt = 32'hFFFF_FFFF;
                    4: cnt = 32'($urandom_range(0, 511)) - 32'd256;
                    default: cnt = $urandom;
                endcase
                {f[7], f[6], f[5], f[4]} = cnt;
            end
            SHAPE_BUF_FULL, SHAPE_BUF_EMPTY, SHAPE_BUF_OTHER: begin
                f[0] = dcrc_pkg::B_CTRL_LO;
                f[1] = dcrc_pkg::B_CTRL_HI;
                f[2] = dcrc_pkg::B_BUF_SUB;
                if (shape == SHAPE_BUF_FULL) begin
                    f[4] = dcrc_pkg::B_BUF_FULL;
                end else if (shape == SHAPE_BUF_EMPTY) begin
                    f[4] = dcrc_pkg::B_BUF_EMPTY;
                end else begin
                    f[3] = dcrc_pkg::B_BUF_OTHER;
                    // keep clear of the full and empty codes
                    if (f[4] == dcrc_pkg::B_BUF_FULL || f[4] == dcrc_pkg::B_BUF_EMPTY) begin
                        f[4] = f[4] | 8'h01;
                    end
                end
            end
            SHAPE_ENDED: begin
                f[0] = dcrc_pkg::B_END_LO;
                f[1] = dcrc_pkg::B_END_HI;
            end
            SHAPE_TARGET: begin
                f[1] = dcrc_pkg::B_OBJ_TGT_LO;
                f[2] = dcrc_pkg::B_OBJ_HI;
            end
            SHAPE_CONTROL: begin
                f[0] = dcrc_pkg::B_CTRL_LO;
                f[1] = dcrc_pkg::B_CTRL_HI;
            end
            SHAPE_FAULT: begin
                {f[1], f[0]} = dcrc_pkg::FAULT_PAIRS[$urandom_range(0, dcrc_pkg::NUM_FAULTS - 1)];
            end
            default: begin
            end
        endcase
        return f;
    endfunction

    task automatic push_frame(input t_frame f);
        t_command c;
        c.op = CMD_FRAME;
        c.frame = f;
        c.scale = '0;
        pending_words.push_back(c);
    endtask

    task automatic push_encoder(input logic [31:0] cnt);
        t_frame f;
        f = make_frame(SHAPE_ENCODER);
        {f[7], f[6], f[5], f[4]} = cnt;
        push_frame(f);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s at reply %0d: got %h, expected %h",
                 what, reply_count, got, want);
        mismatch_count++;
    endtask

    // sender: bursts of words with random gaps, commands wait for an empty pipe
    always @(posedge i_clk) begin
        logic      frame_valid;
        logic      scale_valid;
        t_command  head;
        if (i_rst_n) begin
            frame_valid = i_in_valid;
            scale_valid = i_cfg_valid;
            if (i_in_valid && o_in_ready) begin
                replies_due.push_back(classify_frame({i_byte7, i_byte6, i_byte5, i_byte4,
                                                      i_byte3, i_byte2, i_byte1, i_byte0}));
                frame_valid = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                scale_now = i_position_scale;
                scale_valid = 1'b0;
            end
            if (!frame_valid && !scale_valid && pending_words.size() != 0) begin
                head = pending_words[0];
                if (head.op == CMD_FRAME) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else begin
                        void'(pending_words.pop_front());
                        {i_byte7, i_byte6, i_byte5, i_byte4,
                         i_byte3, i_byte2, i_byte1, i_byte0} <= head.frame;
                        frame_valid = 1'b1;
                        if (burst_left != 0) begin
                            burst_left--;
                        end else begin
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                            burst_left = $urandom_range(0, 30);
                        end
                    end
                end else if (replies_due.size() != 0) begin
                    settle_left = SETTLE_CYCLES;
                end else if (settle_left != 0) begin
                    settle_left--;
                end else begin
                    void'(pending_words.pop_front());
                    settle_left = SETTLE_CYCLES;
                    if (head.op == CMD_SCALE) begin
                        i_position_scale <= head.scale;
                        scale_valid = 1'b1;
                    end
                end
            end
            i_in_valid <= frame_valid;
            i_cfg_valid <= scale_valid;
        end
    end

    // receiver: stall pattern changes mode every so often
    always @(posedge i_clk) begin
        logic ready_next;
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 150);
        end else begin
            mode_left--;
        end
        pattern_step++;
        case (stall_mode)
            0: ready_next = 1'b1;
            1: ready_next = ($urandom_range(0, 3) != 0);
            2: ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = ((pattern_step % 7) < 4);
        endcase
        i_out_ready <= ready_next;
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (replies_due.size() == 0) begin
                report_mismatch("reply with none due", 64'(o_kind), '0);
            end else begin
                want = replies_due.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", 64'(o_kind), 64'(want.kind));
                if (o_fault !== want.fault)
                    report_mismatch("fault", 64'(o_fault), 64'(want.fault));
                if (o_position !== want.position)
                    report_mismatch("position", {24'b0, o_position}, {24'b0, want.position});
                if (o_target_reached !== want.target)
                    report_mismatch("target_reached", 64'(o_target_reached), 64'(want.target));
                if (o_movement_done !== want.done)
                    report_mismatch("movement_done", 64'(o_movement_done), 64'(want.done));
                if (o_buffer_full !== want.full)
                    report_mismatch("buffer_full", 64'(o_buffer_full), 64'(want.full));
            end
            reply_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_frame       f;
        t_command     c;
        logic [31:0]  phase_scale;
        int           roll;

        // directed words under the reset scale
        push_encoder(32'h0000_0000);
        push_encoder(32'h0000_0001);
        push_encoder(32'h7FFF_FFFF);
        push_encoder(32'h8000_0000);
        push_encoder(32'hFFFF_FFFF);
        push_frame(make_frame(SHAPE_BUF_FULL));
        push_frame(make_frame(SHAPE_BUF_OTHER));
        push_frame(make_frame(SHAPE_BUF_EMPTY));
        // full code wins over the other-buffer subindex
        f = make_frame(SHAPE_BUF_FULL);
        f[3] = dcrc_pkg::B_BUF_OTHER;
        push_frame(f);
        push_frame(make_frame(SHAPE_ENDED));
        f = make_frame(SHAPE_TARGET);
        f[5][2] = 1'b1;
        push_frame(f);
        f[5][2] = 1'b0;
        push_frame(f);
        push_frame(make_frame(SHAPE_CONTROL));
        // control pair that only misses the buffer subindex
        f = make_frame(SHAPE_BUF_OTHER);
        f[2] = ~dcrc_pkg::B_BUF_SUB;
        push_frame(f);
        f = make_frame(SHAPE_NOISE);
        {f[1], f[0]} = dcrc_pkg::FAULT_PAIRS[0];
        push_frame(f);
        {f[1], f[0]} = dcrc_pkg::FAULT_PAIRS[dcrc_pkg::NUM_FAULTS - 1];
        push_frame(f);
        push_frame('0);
        push_frame('1);
        push_frame(make_frame(SHAPE_ENDED));

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: phase_scale = 32'h0000_0000;
                1: phase_scale = 32'hFFFF_FFFF;
                2: phase_scale = 32'h0000_0001;
                5: phase_scale = dcrc_pkg::SCALE_RESET;
                default: phase_scale = $urandom;
            endcase
            c.op = CMD_SCALE;
            c.frame = '0;
            c.scale = phase_scale;
            pending_words.push_back(c);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (p == 2 && k == PHASE_WORDS / 2) begin
                    // hold the sender until the pipe runs dry
                    c.op = CMD_DRAIN;
                    pending_words.push_back(c);
                end
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    f = make_frame(t_shape'($urandom_range(0, SHAPE_FAULT)));
                end else if (roll < 85) begin
                    // well-formed frame with one bit flipped in the decoded bytes
                    f = make_frame(t_shape'($urandom_range(0, SHAPE_FAULT)));
                    f[$urandom_range(0, 4)][$urandom_range(0, 7)] ^= 1'b1;
                end else begin
                    f = make_frame(SHAPE_NOISE);
                end
                push_frame(f);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || i_cfg_valid
               || replies_due.size() != 0);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && replies_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
